// File: rtl/sgic_pkg.sv
// Shared types and codes for the small graph isomorphism checker.
// No dependencies; used by sgic_ctrl, sgic_dp and the top level.
package sgic_pkg;

    localparam logic [1:0] ACT_ADD_ONE  = 2'd0;
    localparam logic [1:0] ACT_ADD_TWO  = 2'd1;
    localparam logic [1:0] ACT_COMPARE  = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;   // no effect

    localparam logic [3:0] VCOUNT_RESET = 4'd8;
    localparam logic [4:0] ECOUNT_MAX   = 5'd31;

    typedef struct packed {
        logic load_one;   // add edge to graph one
        logic load_two;   // add edge to graph two
        logic start;      // identity mapping, reset search counters
        logic row_step;   // compare one adjacency row, advance row
        logic heap_step;  // one step of the permutation generator
        logic finish;     // load result register, clear stores
        logic iso;        // result bit for finish
    } sgic_cmd_t;

    typedef struct packed {
        logic cnt_eq;     // edge counts equal
        logic mismatch;   // current row differs under current mapping
        logic row_last;   // current row is the final one
        logic swapped;    // heap step produced a new mapping
        logic perm_done;  // all mappings visited
        logic out_free;   // result register can take a result
    } sgic_stat_t;

endpackage

// File: rtl/sgic_ctrl.sv
// Controller for the graph isomorphism checker: load, row check, permutation step.
// Depends on sgic_pkg.
module sgic_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_acc,
    input  logic [1:0]         action,
    input  sgic_pkg::sgic_stat_t stat,
    output sgic_pkg::sgic_cmd_t  cmd,
    output logic               idle
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_HEAP  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   found_reg, found_next;

    assign idle = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        cmd        = '0;
        cmd.iso    = found_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (action)
                        sgic_pkg::ACT_ADD_ONE: cmd.load_one = 1'b1;
                        sgic_pkg::ACT_ADD_TWO: cmd.load_two = 1'b1;
                        sgic_pkg::ACT_COMPARE: begin
                            cmd.start  = 1'b1;
                            found_next = 1'b0;
                            state_next = stat.cnt_eq ? ST_CHECK : ST_FIN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                cmd.row_step = 1'b1;
                if (stat.mismatch) begin
                    state_next = ST_HEAP;
                end else if (stat.row_last) begin
                    found_next = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_HEAP: begin
                cmd.heap_step = 1'b1;
                if (stat.perm_done) begin
                    state_next = ST_FIN;
                end else if (stat.swapped) begin
                    state_next = ST_CHECK;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

// File: rtl/sgic_dp.sv
// Datapath: adjacency stores, edge counts, mapping generator, row compare, result register.
// Depends on sgic_pkg.
module sgic_dp #(
    parameter int MAX_VERTICES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic [3:0]         end_a,
    input  logic [3:0]         end_b,
    input  sgic_pkg::sgic_cmd_t  cmd,
    output sgic_pkg::sgic_stat_t stat,
    output logic               m_valid,
    output logic               m_iso,
    input  logic               m_ready
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [4:0] MV5 = 5'(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] adj1_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj2_reg [MAX_VERTICES];
    logic [4:0]              cnt1_reg, cnt2_reg;
    logic [3:0]              vcount_reg;
    logic [IW-1:0]           perm_reg [MAX_VERTICES];
    logic [IW-1:0]           hc_reg   [MAX_VERTICES];
    logic [CW-1:0]           hi_reg;
    logic [IW-1:0]           row_reg;
    logic                    out_valid_reg, out_iso_reg;

    // effective vertex count, clamped to 1..MAX_VERTICES
    logic [4:0]    n_eff;
    always_comb begin
        if (vcount_reg == 4'd0)               n_eff = 5'd1;
        else if ({1'b0, vcount_reg} > MV5)    n_eff = MV5;
        else                                  n_eff = {1'b0, vcount_reg};
    end

    // edge load
    logic                    edge_ok, dup;
    logic [IW-1:0]           ex, ey;
    logic [MAX_VERTICES-1:0] ld_row;
    assign edge_ok = (end_a != 4'd0) && ({1'b0, end_a} <= n_eff) &&
                     (end_b != 4'd0) && ({1'b0, end_b} <= n_eff);
    assign ex      = IW'(end_a - 4'd1);
    assign ey      = IW'(end_b - 4'd1);
    assign ld_row  = cmd.load_one ? adj1_reg[ex] : adj2_reg[ex];
    assign dup     = ld_row[ey];

    // row compare under current mapping
    logic [MAX_VERTICES-1:0] row1, row_map;
    assign row1 = adj1_reg[perm_reg[row_reg]];
    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            row_map[j] = row1[perm_reg[j]];
        end
    end

    // permutation generator step (iterative Heap)
    logic          hi_done, do_swap;
    logic [IW-1:0] hi_idx, sw_idx;
    assign hi_idx  = IW'(hi_reg);
    assign hi_done = ({{(5-CW){1'b0}}, hi_reg} >= n_eff);
    assign do_swap = !hi_done && ({{(CW-IW){1'b0}}, hc_reg[hi_idx]} < hi_reg);
    assign sw_idx  = hi_reg[0] ? hc_reg[hi_idx] : '0;

    assign stat.cnt_eq    = (cnt1_reg == cnt2_reg);
    assign stat.mismatch  = (adj2_reg[row_reg] != row_map);
    assign stat.row_last  = (row_reg == IW'(MAX_VERTICES - 1));
    assign stat.swapped   = do_swap;
    assign stat.perm_done = hi_done;
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_iso   = out_iso_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                adj1_reg[i] <= '0;
                adj2_reg[i] <= '0;
            end
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            vcount_reg    <= sgic_pkg::VCOUNT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) vcount_reg <= cfg_wr_data;
            if (m_ready) out_valid_reg <= 1'b0;
            if (cmd.load_one && edge_ok && !dup) begin
                adj1_reg[ex][ey] <= 1'b1;
                adj1_reg[ey][ex] <= 1'b1;
                if (cnt1_reg < sgic_pkg::ECOUNT_MAX) cnt1_reg <= cnt1_reg + 5'd1;
            end
            if (cmd.load_two && edge_ok && !dup) begin
                adj2_reg[ex][ey] <= 1'b1;
                adj2_reg[ey][ex] <= 1'b1;
                if (cnt2_reg < sgic_pkg::ECOUNT_MAX) cnt2_reg <= cnt2_reg + 5'd1;
            end
            if (cmd.finish) begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    adj1_reg[i] <= '0;
                    adj2_reg[i] <= '0;
                end
                cnt1_reg      <= '0;
                cnt2_reg      <= '0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // search state and result payload
    always_ff @(posedge aclk) begin
        if (cmd.finish) out_iso_reg <= cmd.iso;
        if (cmd.start) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                perm_reg[i] <= IW'(i);
                hc_reg[i]   <= '0;
            end
            hi_reg  <= CW'(1);
            row_reg <= '0;
        end else if (cmd.row_step) begin
            row_reg <= row_reg + IW'(1);
        end else if (cmd.heap_step) begin
            row_reg <= '0;
            if (do_swap) begin
                perm_reg[sw_idx] <= perm_reg[hi_idx];
                perm_reg[hi_idx] <= perm_reg[sw_idx];
                hc_reg[hi_idx]   <= hc_reg[hi_idx] + IW'(1);
                hi_reg           <= CW'(1);
            end else if (!hi_done) begin
                hc_reg[hi_idx]   <= '0;
                hi_reg           <= hi_reg + CW'(1);
            end
        end
    end

endmodule

// File: rtl/small_graph_isomorphism_check_top.sv
// Top level of the small graph isomorphism checker: stream ports, config, assertions.
// Depends on sgic_pkg, sgic_ctrl and sgic_dp.
//
//  channel   | dir | beat contents
//  ----------+-----+-----------------------------------------------
//  s_axis    | in  | action, end_a, end_b  (one edge or a compare)
//  m_axis    | out | isomorphic            (one beat per compare)
//  cfg       | in  | vertex_count          (write only)
//
// Edge beats are taken while the checker is idle. A compare beat walks the vertex mappings:
// for each mapping the adjacency rows are checked in turn (stopping at the first
// mismatching row, at most MAX_VERTICES), then the permutation generator steps;
// s_tready is low throughout. Reset is synchronous, active low. Edge beats are
// still taken while a result waits on m_axis; a finished compare holds until the
// result register is free.
module small_graph_isomorphism_check_top #(
    parameter int MAX_VERTICES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // vertex_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [1:0] action, [5:2] end_a, [9:6] end_b, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // [0] isomorphic, rest zero
);

    sgic_pkg::sgic_cmd_t  cmd;
    sgic_pkg::sgic_stat_t stat;
    logic in_acc, idle, iso;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = idle;
    assign m_tdata  = {7'd0, iso};

    sgic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (in_acc),
        .action  (s_tdata[1:0]),
        .stat    (stat),
        .cmd     (cmd),
        .idle    (idle)
    );

    sgic_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .end_a       (s_tdata[5:2]),
        .end_b       (s_tdata[9:6]),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_tvalid),
        .m_iso       (iso),
        .m_ready     (m_tready)
    );

    // a compare beat closes the input until its result is loaded into the result register
    a_compare_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tdata[1:0] == sgic_pkg::ACT_COMPARE) |=> !s_tready)
        else $error("input open straight after compare");

    // a new result only comes from the busy phase
    a_result_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while idle");

    // stores are only loaded while idle
    a_load_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_one || cmd.load_two || cmd.start) |-> idle)
        else $error("load or start outside idle");

endmodule
